// ----- rtl/core/hole_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hole_pkg: shared types and constants
// Field widths, register indexes, status codes and the divider handshake.
// ----------------------------------------------------------------------------
package hole_pkg;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int LOG_FRAC  = 24;
  localparam int ROOT_BITS = 47;
  localparam int SCALE_W   = 31;
  localparam int GAMMA_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int STAT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_NUM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_DEN      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT      = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd65536;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 4'd1;

  localparam logic [DW-1:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SMIN = 32'h8000_0000;

  // log2 offset of one in Q16.16, with LOG_FRAC fraction bits
  localparam logic signed [30:0] LOG_OFF = 31'(FB * (2 ** LOG_FRAC));

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } hole_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               sat;
    logic signed [31:0] quot;
  } hole_div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/hole_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hole_if: channel interfaces
// Cell input, field output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface hole_in_if import hole_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 first_cell;
  logic signed [DW-1:0] b_x;
  logic signed [DW-1:0] b_y;
  logic signed [DW-1:0] b_z;
  logic signed [DW-1:0] ion_jx;
  logic signed [DW-1:0] ion_jy;
  logic signed [DW-1:0] ion_jz;
  logic signed [DW-1:0] density;
  modport source (output valid, first_cell, b_x, b_y, b_z, ion_jx, ion_jy, ion_jz, density,
                  input ready);
  modport sink (input valid, first_cell, b_x, b_y, b_z, ion_jx, ion_jy, ion_jz, density,
                output ready);
endinterface

interface hole_out_if import hole_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] e_x;
  logic signed [DW-1:0] e_y;
  logic signed [DW-1:0] e_z;
  logic [STAT_W-1:0]    status;
  modport source (output valid, e_x, e_y, e_z, status, input ready);
  modport sink (input valid, e_x, e_y, e_z, status, output ready);
endinterface

interface hole_cfg_if import hole_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DW-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hole_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hole_div: serial fixed-point divider
// Computes num * 2^FB / den truncated toward zero, one quotient bit a cycle,
// with clamping to the signed 32-bit range.
// ----------------------------------------------------------------------------
module hole_div import hole_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hole_div_req_t req_i,
  output hole_div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, lo_q, q_q, dd_q, quot_q;
  logic        neg_q, sat_q;

  logic [63:0] n_abs;
  logic [31:0] d_abs;
  logic [46:0] lim;
  logic        big;
  logic [32:0] rem2;
  logic        ge;
  logic [31:0] rem_n, q_n;

  always_comb begin
    n_abs = req_i.num[63] ? 64'(-req_i.num) : req_i.num;
    d_abs = req_i.den[31] ? 32'(-req_i.den) : req_i.den;
    lim   = {d_abs, 15'd0} + 47'(d_abs);
    // quotient above 2^15 cannot fit
    big   = n_abs >= 64'(lim);
    rem2  = {rem_q, lo_q[31]};
    ge    = rem2 >= {1'b0, dd_q};
    rem_n = ge ? 32'(rem2 - {1'b0, dd_q}) : rem2[31:0];
    q_n   = {q_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= (busy_q && cnt_q == 5'd0) || (!busy_q && req_i.start && big);
      if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end
      end else if (req_i.start && !big) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_n;
      lo_q  <= {lo_q[30:0], 1'b0};
      q_q   <= q_n;
      if (cnt_q == 5'd0) begin
        if (!neg_q) begin
          sat_q  <= q_n[31];
          quot_q <= q_n[31] ? SMAX : q_n;
        end else begin
          sat_q  <= q_n > SMIN;
          quot_q <= (q_n > SMIN) ? SMIN : 32'(-q_n);
        end
      end
    end else if (req_i.start) begin
      neg_q <= req_i.num[63] ^ req_i.den[31];
      dd_q  <= d_abs;
      rem_q <= n_abs[FB+31:FB];
      lo_q  <= {n_abs[FB-1:0], {(DW-FB){1'b0}}};
      q_q   <= '0;
      if (big) begin
        sat_q  <= 1'b1;
        quot_q <= (req_i.num[63] ^ req_i.den[31]) ? SMIN : SMAX;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

// ----- rtl/core/hybrid_ohms_law_efield.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hybrid_ohms_law_efield: 1-D hybrid Ohm's law electric field
// Streams grid cells (B, ion current, density in Q16.16) and returns E
// between each adjacent pair, with electron pressure from a polytropic law.
// ----------------------------------------------------------------------------
// Usage
//   item_i takes one cell per beat; a beat with first_cell set starts a line
//   and yields no result. Every other beat yields one beat on res_o.
//   cfg_i writes the five registers; write only while the block is idle.
// Work per cell
//   A cell with positive density finds the pressure root bit by bit over
//   47 candidates, each needing a log2 of 24 squarings on the one shared
//   34x34 multiplier. A cell with non-positive density skips the root.
//   The E field uses the multiplier and three serial divisions, which are
//   skipped when the mean density is zero. item_i is ready only while the
//   sequencer is idle.
// Reset
//   Registers return to 1.0 scales and exponent 1/1; the stored previous
//   cell is zero, so a pair without a line start uses a zero neighbor.
// Stall
//   A result waits in the output register; the next cell is accepted and
//   processed meanwhile, and finishes only once that register is free.
// ----------------------------------------------------------------------------
module hybrid_ohms_law_efield import hole_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hole_cfg_if.sink   cfg_i,
  hole_in_if.sink    item_i,
  hole_out_if.source res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_LNORM, S_LSQ, S_RHS, S_CAND, S_CMP,
    S_PLO, S_PHI, S_PFIN, S_EPREP, S_EMUL, S_DIV, S_OUT
  } state_e;

  function automatic logic [5:0] lead_one(input logic [ROOT_BITS-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < ROOT_BITS; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [32:0] clamp_dw(input logic signed [67:0] x);
    logic [32:0] r;
    if (x > 68'sd2147483647) r = {1'b1, SMAX};
    else if (x < -68'sd2147483648) r = {1'b1, SMIN};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  function automatic logic [31:0] half_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  // configuration
  logic [SCALE_W-1:0] ps_q, ds_q, gs_q;
  logic [GAMMA_W-1:0] gn_q, gd_q, gd_eff;

  // control
  state_e      state_q;
  logic [4:0]  cnt_q;
  logic [3:0]  step_q;
  logic [1:0]  dsel_q;
  logic        ov_q;
  logic signed [DW-1:0] oex_q, oey_q, oez_q;
  logic [STAT_W-1:0]    ost_q;

  // previous cell
  logic signed [DW-1:0] pbx_q, pby_q, pbz_q, pjx_q, pjy_q, pjz_q, prho_q;
  logic [DW-1:0]        ppe_q;

  // current cell and working registers
  logic                 first_q;
  logic signed [DW-1:0] bx_q, by_q, bz_q, jx_q, jy_q, jz_q, rho_q;
  logic [ROOT_BITS-1:0] lv_q, r_q;
  logic [5:0]           lp_q, bit_q;
  logic [30:0]          m_q;
  logic [LOG_FRAC-1:0]  frac_q;
  logic                 lsel_q;
  logic [35:0]          rhs_q;
  logic [54:0]          pacc_q;
  logic [DW-1:0]        pe_q;
  logic signed [DW-1:0] hjy_q, hjz_q, abx_q, aby_q, abz_q, dmean_q;
  logic signed [DW-1:0] jex_q, jey_q, jez_q;
  logic signed [67:0]   acc_q, prod_q;
  logic signed [63:0]   nx_q, ny_q, nz_q;
  logic signed [DW-1:0] ex_q, ey_q, ez_q;
  logic                 sat_q, zd_q;

  // combinational
  logic                 item_acc, out_free, upd;
  logic signed [33:0]   mul_a, mul_b;
  logic signed [67:0]   mul_p;
  logic [ROOT_BITS-1:0] base_c, norm_c;
  logic [5:0]           lp_c;
  logic [31:0]          sq_c;
  logic signed [30:0]   ldiff_c;
  logic signed [67:0]   rhs_ext, psh_c, jt_c, diff_c, dsh_c;
  logic signed [DW-1:0] hsel_c, hjx_c;
  logic [32:0]          jcl_c;
  logic [78:0]          ptot_c;
  logic                 rho_pos;
  logic signed [32:0]   dbz_c, dby_c, dpe_c;
  hole_div_req_t        div_req;
  hole_div_rsp_t        div_rsp;

  assign item_acc     = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !ov_q || res_o.ready;
  assign upd          = (state_q == S_EPREP && first_q) || (state_q == S_OUT && out_free);
  assign gd_eff       = (gd_q == '0) ? GAMMA_RESET : gd_q;

  always_comb begin
    lp_c    = lead_one(lv_q);
    norm_c  = (lp_c >= 6'd30) ? (lv_q >> (lp_c - 6'd30)) : (lv_q << (6'd30 - lp_c));
    ldiff_c = $signed({1'b0, lp_q, frac_q}) - LOG_OFF;
    rhs_ext = {{32{rhs_q[35]}}, rhs_q};
    rho_pos = !rho_q[31] && (rho_q != '0);
    dbz_c   = {pbz_q[31], pbz_q} - {bz_q[31], bz_q};
    dby_c   = {by_q[31], by_q} - {pby_q[31], pby_q};
    dpe_c   = {1'b0, pe_q} - {1'b0, ppe_q};
    hjx_c   = half_sum(pjx_q, jx_q);
    hsel_c  = (step_q == 4'd1) ? hjy_q : hjz_q;
    psh_c   = prod_q >>> FB;
    jt_c    = psh_c - {{36{hsel_c[31]}}, hsel_c};
    jcl_c   = clamp_dw(jt_c);
    diff_c  = acc_q - prod_q;
    dsh_c   = diff_c >>> FB;
    ptot_c  = {24'd0, pacc_q} + {1'b0, prod_q[53:0], 24'd0};
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_BASE: begin
        mul_a = {3'd0, ds_q};
        mul_b = {{2{rho_q[31]}}, rho_q};
      end
      S_LSQ: begin
        mul_a = {3'd0, m_q};
        mul_b = {3'd0, m_q};
      end
      S_RHS: begin
        mul_a = {30'd0, gn_q};
        mul_b = {{3{ldiff_c[30]}}, ldiff_c};
      end
      S_CMP: begin
        mul_a = {30'd0, gd_eff};
        mul_b = {{3{ldiff_c[30]}}, ldiff_c};
      end
      S_PLO: begin
        mul_a = {3'd0, ps_q};
        mul_b = {10'd0, r_q[23:0]};
      end
      S_PHI: begin
        mul_a = {3'd0, ps_q};
        mul_b = {11'd0, r_q[46:24]};
      end
      S_EMUL: begin
        case (step_q)
          4'd0: begin mul_a = {dbz_c[32], dbz_c}; mul_b = {3'd0, gs_q}; end
          4'd1: begin mul_a = {dby_c[32], dby_c}; mul_b = {3'd0, gs_q}; end
          4'd2: begin mul_a = {{2{jey_q[31]}}, jey_q}; mul_b = {{2{abz_q[31]}}, abz_q}; end
          4'd3: begin mul_a = {{2{jez_q[31]}}, jez_q}; mul_b = {{2{aby_q[31]}}, aby_q}; end
          4'd4: begin mul_a = {dpe_c[32], dpe_c}; mul_b = {3'd0, gs_q}; end
          4'd5: begin mul_a = {{2{jez_q[31]}}, jez_q}; mul_b = {{2{abx_q[31]}}, abx_q}; end
          4'd6: begin mul_a = {{2{jex_q[31]}}, jex_q}; mul_b = {{2{abz_q[31]}}, abz_q}; end
          4'd7: begin mul_a = {{2{jex_q[31]}}, jex_q}; mul_b = {{2{aby_q[31]}}, aby_q}; end
          4'd8: begin mul_a = {{2{jey_q[31]}}, jey_q}; mul_b = {{2{abx_q[31]}}, abx_q}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign base_c = mul_p[FB+ROOT_BITS-1:FB];
  assign sq_c   = mul_p[61:30];

  always_comb begin
    div_req.start = ((state_q == S_EMUL) && (step_q == 4'd9) && (dmean_q != '0)) ||
                    ((state_q == S_DIV) && div_rsp.done && (dsel_q != 2'd2));
    div_req.num   = (state_q == S_EMUL) ? nx_q : ((dsel_q == 2'd0) ? ny_q : nz_q);
    div_req.den   = dmean_q;
  end

  hole_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= SCALE_RESET;
      ds_q <= SCALE_RESET;
      gs_q <= SCALE_RESET;
      gn_q <= GAMMA_RESET;
      gd_q <= GAMMA_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PRESSURE_SCALE: ps_q <= cfg_i.data[SCALE_W-1:0];
        CFG_DENSITY_SCALE:  ds_q <= cfg_i.data[SCALE_W-1:0];
        CFG_GRADIENT_SCALE: gs_q <= cfg_i.data[SCALE_W-1:0];
        CFG_GAMMA_NUM:      gn_q <= cfg_i.data[GAMMA_W-1:0];
        CFG_GAMMA_DEN:      gd_q <= cfg_i.data[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, previous cell and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      dsel_q  <= '0;
      ov_q    <= 1'b0;
      oex_q   <= '0;
      oey_q   <= '0;
      oez_q   <= '0;
      ost_q   <= ST_OK;
      pbx_q   <= '0;
      pby_q   <= '0;
      pbz_q   <= '0;
      pjx_q   <= '0;
      pjy_q   <= '0;
      pjz_q   <= '0;
      prho_q  <= '0;
      ppe_q   <= '0;
    end else begin
      if (res_o.ready && !(state_q == S_OUT && out_free)) ov_q <= 1'b0;
      if (upd) begin
        pbx_q  <= bx_q;
        pby_q  <= by_q;
        pbz_q  <= bz_q;
        pjx_q  <= jx_q;
        pjy_q  <= jy_q;
        pjz_q  <= jz_q;
        prho_q <= rho_q;
        ppe_q  <= pe_q;
      end
      case (state_q)
        S_IDLE: begin
          if (item_acc) state_q <= S_BASE;
        end
        S_BASE: begin
          if (!rho_pos || base_c == '0) state_q <= S_EPREP;
          else state_q <= S_LNORM;
        end
        S_LNORM: begin
          cnt_q   <= 5'(LOG_FRAC);
          state_q <= S_LSQ;
        end
        S_LSQ: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) state_q <= lsel_q ? S_CMP : S_RHS;
        end
        S_RHS:  state_q <= S_CAND;
        S_CAND: state_q <= S_LNORM;
        S_CMP: begin
          if (bit_q == '0) state_q <= S_PLO;
          else state_q <= S_CAND;
        end
        S_PLO: begin
          if (ps_q == '0 || r_q == '0) state_q <= S_EPREP;
          else state_q <= S_PHI;
        end
        S_PHI:  state_q <= S_PFIN;
        S_PFIN: state_q <= S_EPREP;
        S_EPREP: begin
          step_q  <= '0;
          state_q <= first_q ? S_IDLE : S_EMUL;
        end
        S_EMUL: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd9) begin
            dsel_q  <= '0;
            state_q <= (dmean_q == '0) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (dsel_q == 2'd2) state_q <= S_OUT;
            else dsel_q <= dsel_q + 2'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            oex_q   <= ex_q;
            oey_q   <= ey_q;
            oez_q   <= ez_q;
            ost_q   <= zd_q ? ST_ZERO_DEN : (sat_q ? ST_SAT : ST_OK);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          first_q <= item_i.first_cell;
          bx_q    <= item_i.b_x;
          by_q    <= item_i.b_y;
          bz_q    <= item_i.b_z;
          jx_q    <= item_i.ion_jx;
          jy_q    <= item_i.ion_jy;
          jz_q    <= item_i.ion_jz;
          rho_q   <= item_i.density;
        end
      end
      S_BASE: begin
        pe_q   <= '0;
        lv_q   <= base_c;
        lsel_q <= 1'b0;
      end
      S_LNORM: begin
        lp_q   <= lp_c;
        m_q    <= norm_c[30:0];
        frac_q <= '0;
      end
      S_LSQ: begin
        // renormalize the squared mantissa, shifting out one log bit
        if (sq_c[31]) begin
          m_q    <= sq_c[31:1];
          frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
        end else begin
          m_q    <= sq_c[30:0];
          frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
        end
      end
      S_RHS: begin
        rhs_q <= mul_p[35:0];
        r_q   <= '0;
        bit_q <= 6'(ROOT_BITS - 1);
      end
      S_CAND: begin
        lv_q   <= r_q | ({{(ROOT_BITS-1){1'b0}}, 1'b1} << bit_q);
        lsel_q <= 1'b1;
      end
      S_CMP: begin
        if (mul_p <= rhs_ext) r_q <= lv_q;
        bit_q <= bit_q - 6'd1;
      end
      S_PHI: pacc_q <= prod_q[54:0];
      S_PFIN: pe_q <= (ptot_c[78:47] != '0) ? SMAX : ptot_c[47:16];
      S_EPREP: begin
        hjy_q   <= half_sum(pjy_q, jy_q);
        hjz_q   <= half_sum(pjz_q, jz_q);
        abx_q   <= half_sum(pbx_q, bx_q);
        aby_q   <= half_sum(pby_q, by_q);
        abz_q   <= half_sum(pbz_q, bz_q);
        dmean_q <= half_sum(prho_q, rho_q);
        sat_q   <= (hjx_c == SMIN);
        jex_q   <= (hjx_c == SMIN) ? SMAX : 32'(-hjx_c);
      end
      S_EMUL: begin
        case (step_q)
          4'd1: begin jey_q <= jcl_c[31:0]; sat_q <= sat_q | jcl_c[32]; end
          4'd2: begin jez_q <= jcl_c[31:0]; sat_q <= sat_q | jcl_c[32]; end
          4'd3, 4'd6, 4'd8: acc_q <= prod_q;
          4'd4: nx_q <= dsh_c[63:0];
          4'd5: nx_q <= nx_q - psh_c[63:0];
          4'd7: ny_q <= dsh_c[63:0];
          4'd9: begin
            nz_q <= dsh_c[63:0];
            zd_q <= (dmean_q == '0);
            ex_q <= '0;
            ey_q <= '0;
            ez_q <= '0;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          sat_q <= sat_q | div_rsp.sat;
          case (dsel_q)
            2'd0: ex_q <= div_rsp.quot;
            2'd1: ey_q <= div_rsp.quot;
            default: ez_q <= div_rsp.quot;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid  = ov_q;
  assign res_o.e_x    = oex_q;
  assign res_o.e_y    = oey_q;
  assign res_o.e_z    = oez_q;
  assign res_o.status = ost_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == S_OUT))
    else $error("result beat raised outside the output step");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == ST_ZERO_DEN) |->
      (res_o.e_x == '0 && res_o.e_y == '0 && res_o.e_z == '0))
    else $error("zero density result carries a nonzero field");

endmodule
`default_nettype wire

// ----- tb/hybrid_ohms_law_efield_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_ohms_law_efield_tb: self-checking bench for the 1-D Ohm's law E field
// Streams grid cells through the block and predicts the E field and status of
// each adjacent cell pair. The prediction covers the pressure root, the
// saturation rules and the register settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module hybrid_ohms_law_efield_tb;
  import hole_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 1600;

  typedef struct {
    bit                   first;
    logic signed [DW-1:0] bx, by, bz, jx, jy, jz, rho;
  } cell_t;

  typedef struct {
    logic [DW-1:0]     ex, ey, ez;
    logic [STAT_W-1:0] status;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hole_cfg_if cfg_if ();
  hole_in_if  cell_if ();
  hole_out_if field_if ();

  hybrid_ohms_law_efield dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .item_i (cell_if.sink),
    .res_o  (field_if.source)
  );

  // predictor copy of the registers and the stored neighbor cell
  longint p_scale, d_scale, g_scale, g_num, g_den;
  longint nb_bx, nb_by, nb_bz, nb_jx, nb_jy, nb_jz, nb_rho, nb_pe;

  field_t field_q[$];
  int     err_cnt   = 0;
  int     hold_cnt  = 0;
  bit     no_idle   = 1'b0;
  int     quiet_cnt = 0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    cfg_if.valid = 1'b0;  cfg_if.index = '0;  cfg_if.data = '0;
    cell_if.valid = 1'b0; cell_if.first_cell = 1'b0;
    cell_if.b_x = '0; cell_if.b_y = '0; cell_if.b_z = '0;
    cell_if.ion_jx = '0; cell_if.ion_jy = '0; cell_if.ion_jz = '0;
    cell_if.density = '0;
    field_if.ready = 1'b0;
  end

  // ---------------- prediction ----------------
  function automatic longint log2_fix(logic [63:0] v);
    int          p;
    logic [63:0] m, frac;
    p = 0;
    frac = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(p) << LOG_FRAC) + longint'(frac);
  endfunction

  function automatic longint cell_pressure(longint rho);
    logic [63:0] base, r, c, lim;
    longint      off, rhs, d;
    if (rho <= 0) return 0;
    base = (64'(d_scale) * 64'(rho)) >> FB;
    if (base == 0) return 0;
    d = (g_den != 0) ? g_den : 1;
    off = longint'(FB) << LOG_FRAC;
    rhs = g_num * (log2_fix(base) - off);
    r = 0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (d * (log2_fix(c) - off) <= rhs) r = c;
    end
    if (p_scale == 0 || r == 0) return 0;
    lim = (64'h8000_0000 << FB) - 1;
    if (r > lim / 64'(p_scale)) return 64'h7FFF_FFFF;
    return longint'((64'(p_scale) * r) >> FB);
  endfunction

  function automatic longint sat32(longint x, inout bit sat);
    if (x > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (x < -64'sh8000_0000) begin
      sat = 1'b1;
      return -64'sh8000_0000;
    end
    return x;
  endfunction

  function automatic longint fix_div(longint num, longint den, inout bit sat);
    bit          neg;
    logic [63:0] n, dd, q;
    neg = (num < 0) != (den < 0);
    n  = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
    dd = (den < 0) ? 64'd0 - 64'(den) : 64'(den);
    if (n / dd > (64'd1 << (DW - 1 - FB))) begin
      sat = 1'b1;
      return neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
    end
    q = (n << FB) / dd;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 64'sh7FFF_FFFF;
      end
      return longint'(q);
    end
    if (q > 64'h8000_0000) begin
      sat = 1'b1;
      return -64'sh8000_0000;
    end
    return -longint'(q);
  endfunction

  // returns 1 when the cell closes a pair and fills fld
  function automatic bit efield_predict(cell_t c, output field_t fld);
    longint bx, by, bz, jx, jy, jz, rho, pe, g;
    longint jex, jey, jez, abx, aby, abz, nx, ny, nz, dmean, ex, ey, ez;
    bit     sat;
    bx = longint'(c.bx); by = longint'(c.by); bz = longint'(c.bz);
    jx = longint'(c.jx); jy = longint'(c.jy); jz = longint'(c.jz);
    rho = longint'(c.rho);
    pe = cell_pressure(rho);
    g = g_scale;
    sat = 1'b0;
    ex = 0; ey = 0; ez = 0;
    fld.status = ST_OK;
    if (!c.first) begin
      jex = sat32(-((nb_jx + jx) >>> 1), sat);
      jey = sat32((((nb_bz - bz) * g) >>> FB) - ((nb_jy + jy) >>> 1), sat);
      jez = sat32((((by - nb_by) * g) >>> FB) - ((nb_jz + jz) >>> 1), sat);
      abx = (nb_bx + bx) >>> 1;
      aby = (nb_by + by) >>> 1;
      abz = (nb_bz + bz) >>> 1;
      nx = ((jey * abz - jez * aby) >>> FB) - (((pe - nb_pe) * g) >>> FB);
      ny = (jez * abx - jex * abz) >>> FB;
      nz = (jex * aby - jey * abx) >>> FB;
      dmean = (nb_rho + rho) >>> 1;
      if (dmean == 0) begin
        fld.status = ST_ZERO_DEN;
      end else begin
        ex = fix_div(nx, dmean, sat);
        ey = fix_div(ny, dmean, sat);
        ez = fix_div(nz, dmean, sat);
        fld.status = sat ? ST_SAT : ST_OK;
      end
    end
    fld.ex = ex[31:0];
    fld.ey = ey[31:0];
    fld.ez = ez[31:0];
    nb_bx = bx; nb_by = by; nb_bz = bz;
    nb_jx = jx; nb_jy = jy; nb_jz = jz;
    nb_rho = rho;
    nb_pe = pe;
    return !c.first;
  endfunction

  // ---------------- channel drivers ----------------
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 17);
  endfunction

  task automatic send_cell(cell_t c);
    field_t fld;
    while (idle_now()) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid      <= 1'b1;
    cell_if.first_cell <= c.first;
    cell_if.b_x <= c.bx; cell_if.b_y <= c.by; cell_if.b_z <= c.bz;
    cell_if.ion_jx <= c.jx; cell_if.ion_jy <= c.jy; cell_if.ion_jz <= c.jz;
    cell_if.density <= c.rho;
    do @(posedge clk_i); while (!cell_if.ready);
    if (efield_predict(c, fld)) field_q.push_back(fld);
  endtask

  task automatic stop_cells();
    cell_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every pending field, then let a trailing line start finish
  task automatic drain();
    stop_cells();
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_PRESSURE_SCALE: p_scale = longint'(val & 32'h7FFF_FFFF);
      CFG_DENSITY_SCALE:  d_scale = longint'(val & 32'h7FFF_FFFF);
      CFG_GRADIENT_SCALE: g_scale = longint'(val & 32'h7FFF_FFFF);
      CFG_GAMMA_NUM:      g_num   = longint'(val & 32'hF);
      CFG_GAMMA_DEN:      g_den   = longint'(val & 32'hF);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [DW-1:0] ps, ds, gs, gn, gd);
    write_reg(CFG_PRESSURE_SCALE, ps);
    write_reg(CFG_DENSITY_SCALE, ds);
    write_reg(CFG_GRADIENT_SCALE, gs);
    write_reg(CFG_GAMMA_NUM, gn);
    write_reg(CFG_GAMMA_DEN, gd);
  endtask

  // ---------------- result side ----------------
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      field_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      field_if.ready <= !idle_now();
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    field_t want;
    if (rst_ni && field_if.valid && field_if.ready) begin
      if (field_q.size() == 0) begin
        report("unexpected field beat, e_x", field_if.e_x, 0);
      end else begin
        want = field_q.pop_front();
        if (field_if.e_x !== want.ex) report("e_x", field_if.e_x, want.ex);
        if (field_if.e_y !== want.ey) report("e_y", field_if.e_y, want.ey);
        if (field_if.e_z !== want.ez) report("e_z", field_if.e_z, want.ez);
        if (field_if.status !== want.status) report("status", field_if.status, want.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cell_if.valid && cell_if.ready) || (field_if.valid && field_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic cell_t mk_cell(bit first, longint b, longint j, longint rho);
    cell_t c;
    c.first = first;
    c.bx = 32'(b); c.by = 32'(b); c.bz = 32'(b);
    c.jx = 32'(j); c.jy = 32'(j); c.jz = 32'(j);
    c.rho = 32'(rho);
    return c;
  endfunction

  function automatic logic [DW-1:0] rnd_word();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? SMAX : SMIN;
      2:       return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic logic [DW-1:0] rnd_density();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return $urandom();
      2:       return 32'(-$signed($urandom_range(1, 32'h0004_0000)));
      3:       return SMAX;
      default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
    endcase
  endfunction

  function automatic cell_t rnd_cell(bit first);
    cell_t c;
    c.first = first;
    c.bx = rnd_word(); c.by = rnd_word(); c.bz = rnd_word();
    c.jx = rnd_word(); c.jy = rnd_word(); c.jz = rnd_word();
    c.rho = rnd_density();
    return c;
  endfunction

  task automatic test_reset_pair();
    // no line start yet: the zeroed neighbor closes the first pair
    send_cell(mk_cell(1'b0, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000));
    send_cell(mk_cell(1'b1, 32'h0000_4000, 32'h0000_0000, 32'h0001_0000));
    send_cell(mk_cell(1'b0, -32'sh0000_4000, 32'h0000_1000, 32'h0001_8000));
    drain();
  endtask

  task automatic test_field_extremes();
    set_regs(32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'd2, 32'd1);
    send_cell(mk_cell(1'b1, SMAX, SMIN, SMAX));
    send_cell(mk_cell(1'b0, SMIN, SMAX, 32'h0000_0001));
    send_cell(mk_cell(1'b0, SMAX, SMAX, SMIN));
    send_cell(mk_cell(1'b0, 32'd0, 32'd0, SMAX));
    drain();
  endtask

  task automatic test_zero_mean_density();
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd1, 32'd1);
    send_cell(mk_cell(1'b1, 32'h0001_0000, 32'h100, 32'h0001_0000));
    send_cell(mk_cell(1'b0, 32'h0002_0000, 32'h200, -32'sh0001_0000));
    send_cell(mk_cell(1'b0, 32'h0003_0000, 32'h300, 32'd1));
    send_cell(mk_cell(1'b0, 32'h0003_0000, 32'h300, 32'd0));
    drain();
  endtask

  task automatic test_exponent_corners();
    // zero numerator, then zero denominator, then both at the field maximum
    set_regs(32'h0003_0000, 32'h0002_0000, 32'h0000_8000, 32'd0, 32'd3);
    send_cell(mk_cell(1'b1, 32'h0001_0000, 32'h10, 32'h0003_0000));
    send_cell(mk_cell(1'b0, 32'h0000_8000, 32'h20, 32'h0000_0100));
    drain();
    set_regs(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'd5, 32'd0);
    send_cell(mk_cell(1'b1, 32'h0001_0000, 32'h10, 32'h0003_0000));
    send_cell(mk_cell(1'b0, 32'h0000_8000, 32'h20, 32'h0000_0001));
    drain();
    set_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'd15, 32'd15);
    send_cell(mk_cell(1'b1, 32'h0001_0000, 32'h10, 32'h0003_0000));
    send_cell(mk_cell(1'b0, 32'h0000_8000, 32'h20, 32'h0005_0000));
    drain();
    // pressure overflow clamps without a flag
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0010, 32'd9, 32'd1);
    send_cell(mk_cell(1'b1, 32'h0001_0000, 32'h10, 32'h0010_0000));
    send_cell(mk_cell(1'b0, 32'h0000_8000, 32'h20, 32'h7000_0000));
    drain();
  endtask

  task automatic test_output_backpressure();
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd5, 32'd3);
    hold_cnt = 5000;
    send_cell(rnd_cell(1'b1));
    for (int i = 0; i < 4; i++) send_cell(rnd_cell(1'b0));
    drain();
  endtask

  task automatic test_random_lines(int n_cells);
    int    left;
    cell_t c;
    left = 0;
    for (int i = 0; i < n_cells; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        c = rnd_cell(1'($urandom_range(0, 1)));
      end else begin
        c = rnd_cell(left == 0);
        left = (left == 0) ? int'($urandom_range(1, 12)) : left - 1;
      end
      send_cell(c);
    end
    drain();
  endtask

  task automatic random_regs();
    set_regs($urandom_range(0, 32'h0004_0000), $urandom_range(32'h0000_4000, 32'h0004_0000),
             $urandom_range(0, 32'h0004_0000), $urandom_range(0, 9), $urandom_range(1, 9));
  endtask

  initial begin
    p_scale = SCALE_RESET; d_scale = SCALE_RESET; g_scale = SCALE_RESET;
    g_num = GAMMA_RESET;   g_den = GAMMA_RESET;
    nb_bx = 0; nb_by = 0; nb_bz = 0; nb_jx = 0; nb_jy = 0; nb_jz = 0;
    nb_rho = 0; nb_pe = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pair();
    test_field_extremes();
    test_zero_mean_density();
    test_exponent_corners();
    test_output_backpressure();
    for (int ph = 0; ph < 4; ph++) begin
      random_regs();
      no_idle = (ph == 2);
      test_random_lines(300);
    end
    no_idle = 1'b0;

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
